FILE: rtl/cft_pkg.sv
package cft_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned COL_W   = 8;

  localparam logic [CHAR_W-1:0]  QUOTE_CHAR = 8'h22;
  localparam logic [CHAR_W-1:0]  COMMA_CHAR = 8'h2C;
  localparam logic [CHAR_W-1:0]  SPACE_CHAR = 8'h20;
  localparam logic [COL_W-1:0]   COL_MAX    = 8'hFF;
  localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 10'd255;

  // result kinds as carried on out_tuser
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    MODE_SKIP   = 3'd0,
    MODE_PLAIN  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QPEND  = 3'd3,
    MODE_DROP   = 3'd4
  } parse_mode_t;

  typedef struct packed {
    logic              vld;
    logic              kind;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic              last;
  } res_t;

endpackage

FILE: rtl/cft_parse.sv
module cft_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cft_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic                          step,
  input  logic [cft_pkg::CHAR_W-1:0]    data_byte,
  input  logic                          row_end,
  output cft_pkg::res_t                 res,
  output cft_pkg::parse_mode_t          mode,
  output logic [cft_pkg::COL_W-1:0]     col
);
  import cft_pkg::*;

  logic [COUNT_W-1:0] max_r;
  parse_mode_t        mode_r, mode_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic               open_r, open_nxt;
  logic               do_keep;
  logic               do_comma;
  logic [CHAR_W-1:0]  keep_ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= MAX_CHARS_RESET;
      mode_r <= MODE_SKIP;
      cnt_r  <= '0;
      col_r  <= '0;
      open_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (step) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        col_r  <= col_nxt;
        open_r <= open_nxt;
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    col_nxt  = col_r;
    open_nxt = open_r;
    do_keep  = 1'b0;
    do_comma = 1'b0;
    keep_ch  = data_byte;
    res.vld  = 1'b0;
    res.kind = KIND_CHAR;
    res.ch   = '0;
    res.col  = col_r;
    res.last = 1'b0;

    if (row_end) begin
      res.vld  = open_r;
      res.kind = KIND_END;
      res.last = 1'b1;
      col_nxt  = '0;
      mode_nxt = MODE_SKIP;
      cnt_nxt  = '0;
      open_nxt = 1'b0;
    end else begin
      open_nxt = 1'b1;
      unique case (mode_r)
        MODE_SKIP: begin
          if (data_byte == COMMA_CHAR) begin
            do_comma = 1'b1;
          end else if (data_byte == QUOTE_CHAR) begin
            mode_nxt = MODE_QUOTED;
          end else if (data_byte != SPACE_CHAR) begin
            mode_nxt = MODE_PLAIN;
            do_keep  = 1'b1;
          end
        end
        MODE_PLAIN: begin
          if (data_byte == COMMA_CHAR) begin
            do_comma = 1'b1;
          end else begin
            do_keep = 1'b1;
          end
        end
        MODE_QUOTED: begin
          // full field: even a comma inside quotes ends it
          if (cnt_r >= max_r) begin
            mode_nxt = MODE_DROP;
            do_comma = (data_byte == COMMA_CHAR);
          end else if (data_byte == QUOTE_CHAR) begin
            mode_nxt = MODE_QPEND;
          end else begin
            do_keep = 1'b1;
          end
        end
        MODE_QPEND: begin
          if (data_byte == QUOTE_CHAR) begin
            mode_nxt = MODE_QUOTED;
            keep_ch  = QUOTE_CHAR;
            do_keep  = 1'b1;
          end else if (data_byte == COMMA_CHAR) begin
            do_comma = 1'b1;
          end else begin
            mode_nxt = MODE_DROP;
          end
        end
        default: begin
          if (data_byte == COMMA_CHAR) begin
            do_comma = 1'b1;
          end else begin
            mode_nxt = MODE_DROP;
          end
        end
      endcase

      if (do_keep) begin
        if (cnt_r < max_r) begin
          res.vld  = 1'b1;
          res.ch   = keep_ch;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          mode_nxt = MODE_DROP;
        end
      end

      if (do_comma) begin
        res.vld  = 1'b1;
        res.kind = KIND_END;
        if (col_r != COL_MAX) begin
          col_nxt = col_r + 1'b1;
        end
        mode_nxt = MODE_SKIP;
        cnt_nxt  = '0;
        open_nxt = 1'b0;
      end
    end
  end

  assign mode = mode_r;
  assign col  = col_r;

endmodule

FILE: rtl/cft_out_stage.sv
module cft_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  cft_pkg::res_t                  res,
  output logic                           free,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [2*cft_pkg::CHAR_W-1:0]   out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import cft_pkg::*;

  logic              vld_r;
  logic              kind_r;
  logic [CHAR_W-1:0] ch_r;
  logic [COL_W-1:0]  col_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res.kind;
      ch_r   <= res.ch;
      col_r  <= res.col;
      last_r <= res.last;
    end
  end

  assign free       = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {col_r, ch_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

FILE: rtl/csv_field_tokenizer.sv
// An accepted input beat reaches out_* through the input register, then
//   the parse logic into the output register.
// Throughput: 1 beat per cycle unless a beat with a result meets a stalled output.
//   A beat that yields no result never waits on out_tready.
// Reset: synchronous, active-low rst_n; empties both registers, returns the
//   parser to skipping spaces at column 0 and sets max_field_chars to 255.
module csv_field_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,   // max_field_chars
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // row_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] char_byte, [15:8] field_index
  output logic        out_tuser,     // result_kind
  output logic        out_tlast      // last_of_row
);
  import cft_pkg::*;

  logic              s0_vld_r;
  logic [CHAR_W-1:0] s0_byte_r;
  logic              s0_end_r;
  logic              consume;
  logic              out_free;
  res_t              res;
  parse_mode_t       mode;
  logic [COL_W-1:0]  col;

  // advance the held beat unless it has a result and the output is stalled
  assign consume   = s0_vld_r && (out_free || !res.vld);
  assign in_tready = !s0_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_tready) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_byte_r <= in_tdata;
      s0_end_r  <= in_tlast;
    end
  end

  cft_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (consume),
    .data_byte   (s0_byte_r),
    .row_end     (s0_end_r),
    .res         (res),
    .mode        (mode),
    .col         (col)
  );

  cft_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume && res.vld),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_CHAR |-> !out_tlast)
    else $error("character beat marked last of row");

  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_END |-> out_tdata[7:0] == '0)
    else $error("field-end beat carries a character");

  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    consume && s0_end_r |=> col == '0 && mode == MODE_SKIP)
    else $error("row end did not reset parser state");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s0_vld_r && res.vld && out_tvalid && !out_tready |-> !consume)
    else $error("result dropped while output stalled");

endmodule
